@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// When ante holds at a clock edge, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

@@ rtl/tor_pkg.sv @@
// ----------------------------------------------------------------------------
// tor_pkg
// Types and constants shared by the tilt orientation controller.
// ----------------------------------------------------------------------------
package tor_pkg;

  localparam int unsigned TiltW = 11;

  // Orientation codes.
  localparam logic [1:0] ORIENT_NORMAL   = 2'd0;
  localparam logic [1:0] ORIENT_LEFT     = 2'd1;
  localparam logic [1:0] ORIENT_INVERTED = 2'd2;
  localparam logic [1:0] ORIENT_RIGHT    = 2'd3;

  // Request codes.
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_FWD  = 2'd1;
  localparam logic [1:0] REQ_BACK = 2'd2;
  localparam logic [1:0] REQ_STOP = 2'd3;

  // Resume orientation value meaning no resume point is recorded.
  localparam logic [2:0] RESUME_NONE = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TILT_LOW   = 3'd0;
  localparam logic [2:0] CFG_TILT_HIGH  = 3'd1;
  localparam logic [2:0] CFG_SIDE_LEFT  = 3'd2;
  localparam logic [2:0] CFG_SIDE_RIGHT = 3'd3;
  localparam logic [2:0] CFG_MID_LEFT   = 3'd4;
  localparam logic [2:0] CFG_MID_RIGHT  = 3'd5;

  // Threshold reset values.
  localparam logic signed [TiltW-1:0] TILT_LOW_RST   = 11'sd465;
  localparam logic signed [TiltW-1:0] TILT_HIGH_RST  = 11'sd525;
  localparam logic signed [TiltW-1:0] SIDE_LEFT_RST  = 11'sd210;
  localparam logic signed [TiltW-1:0] SIDE_RIGHT_RST = 11'sd425;
  localparam logic signed [TiltW-1:0] MID_LEFT_RST   = 11'sd305;
  localparam logic signed [TiltW-1:0] MID_RIGHT_RST  = 11'sd345;

  typedef struct packed {
    logic signed [TiltW-1:0] tilt_low;
    logic signed [TiltW-1:0] tilt_high;
    logic signed [TiltW-1:0] side_left;
    logic signed [TiltW-1:0] side_right;
    logic signed [TiltW-1:0] mid_left;
    logic signed [TiltW-1:0] mid_right;
  } cfg_t;

  typedef struct packed {
    logic                    tablet_mode;
    logic [1:0]              req_type;
    logic signed [TiltW-1:0] accel_x;
    logic signed [TiltW-1:0] accel_y;
  } item_t;

  typedef struct packed {
    logic [1:0] orientation;
    logic       rotated;
    logic       auto_mode;
    logic       entered_tablet;
    logic       left_tablet;
    logic       auto_resumed;
    logic       manual_started;
    logic       step_refused;
    logic       stopped;
  } result_t;

  typedef struct packed {
    logic [1:0] display_orient;
    logic       auto_on;
    logic [2:0] resume_orient;
    logic [1:0] auto_target;
    logic [1:0] held_choice;
    logic       tablet_seen;
    logic       tablet_prev;
    logic       halted;
  } state_t;

endpackage

@@ rtl/tor_classify.sv @@
// ----------------------------------------------------------------------------
// tor_classify
// Sorts one tilt reading into an orientation using the six thresholds.
// ----------------------------------------------------------------------------
module tor_classify (
  input  tor_pkg::cfg_t                   cfg,
  input  logic signed [tor_pkg::TiltW-1:0] accel_x,
  input  logic signed [tor_pkg::TiltW-1:0] accel_y,
  input  logic [1:0]                      held_choice,
  output logic [1:0]                      choice
);
  import tor_pkg::*;

  // One extra bit so that negating the most negative reading stays exact.
  logic signed [TiltW:0] neg_y;
  logic signed [TiltW:0] x_ext;
  logic                  below_band;
  logic                  above_band;

  assign neg_y      = -$signed({accel_y[TiltW-1], accel_y});
  assign x_ext      = $signed({accel_x[TiltW-1], accel_x});
  assign below_band = neg_y < $signed({cfg.tilt_low[TiltW-1], cfg.tilt_low});
  assign above_band = neg_y > $signed({cfg.tilt_high[TiltW-1], cfg.tilt_high});

  always_comb begin
    if (below_band || above_band) begin
      if (x_ext < $signed({cfg.side_left[TiltW-1], cfg.side_left})) begin
        choice = ORIENT_LEFT;
      end else if (x_ext > $signed({cfg.side_right[TiltW-1], cfg.side_right})) begin
        choice = ORIENT_RIGHT;
      end else begin
        choice = below_band ? ORIENT_INVERTED : ORIENT_NORMAL;
      end
    end else begin
      if (x_ext < $signed({cfg.mid_left[TiltW-1], cfg.mid_left})) begin
        choice = ORIENT_LEFT;
      end else if (x_ext > $signed({cfg.mid_right[TiltW-1], cfg.mid_right})) begin
        choice = ORIENT_RIGHT;
      end else begin
        choice = held_choice;
      end
    end
  end

endmodule

@@ rtl/tor_update.sv @@
// ----------------------------------------------------------------------------
// tor_update
// Controller state and the per-transaction state update and result.
// ----------------------------------------------------------------------------
module tor_update (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  tor_pkg::cfg_t    cfg,
  input  tor_pkg::item_t   item,
  output tor_pkg::result_t result
);
  import tor_pkg::*;

  state_t     st_r;
  state_t     st_nxt;
  logic       is_step;
  logic [1:0] step_orient;
  logic [1:0] cls_held;
  logic [1:0] cls_choice;

  assign is_step     = (item.req_type == REQ_FWD) || (item.req_type == REQ_BACK);
  assign step_orient = (item.req_type == REQ_FWD) ? st_r.display_orient + 2'd1
                                                  : st_r.display_orient - 2'd1;
  // A manual step in the same transaction updates the held choice first.
  assign cls_held    = is_step ? step_orient : st_r.held_choice;

  tor_classify u_classify (
    .cfg         (cfg),
    .accel_x     (item.accel_x),
    .accel_y     (item.accel_y),
    .held_choice (cls_held),
    .choice      (cls_choice)
  );

  always_comb begin
    logic rot, ent, lft, res, man, refused;
    st_nxt  = st_r;
    rot     = 1'b0;
    ent     = 1'b0;
    lft     = 1'b0;
    res     = 1'b0;
    man     = 1'b0;
    refused = 1'b0;
    if (!st_r.halted && item.req_type == REQ_STOP) begin
      st_nxt.halted = 1'b1;
    end else if (!st_r.halted) begin
      if (!st_r.tablet_seen || st_r.tablet_prev != item.tablet_mode) begin
        if (item.tablet_mode) begin
          ent = 1'b1;
        end else begin
          lft                   = 1'b1;
          st_nxt.display_orient = ORIENT_NORMAL;
          rot                   = 1'b1;
        end
      end
      if (item.tablet_mode) begin
        if (is_step) begin
          st_nxt.held_choice = step_orient;
          if ({1'b0, step_orient} == st_r.resume_orient) begin
            st_nxt.display_orient = step_orient;
            rot                   = 1'b1;
            st_nxt.auto_on        = 1'b1;
            st_nxt.resume_orient  = RESUME_NONE;
            res                   = 1'b1;
          end else if (st_r.auto_on &&
                       {1'b0, st_r.display_orient} == st_r.resume_orient) begin
            st_nxt.auto_on = 1'b0;
            man            = 1'b1;
          end else begin
            if (st_r.auto_on) begin
              man                  = 1'b1;
              st_nxt.resume_orient = {1'b0, st_r.display_orient};
            end else begin
              st_nxt.display_orient = step_orient;
              rot                   = 1'b1;
            end
            st_nxt.auto_on = 1'b0;
          end
        end
        if (st_nxt.auto_on) begin
          st_nxt.held_choice = cls_choice;
          if (cls_choice != st_r.auto_target) begin
            st_nxt.display_orient = cls_choice;
            rot                   = 1'b1;
            st_nxt.auto_target    = cls_choice;
          end
        end
      end else if (is_step) begin
        refused = 1'b1;
      end
      st_nxt.tablet_prev = item.tablet_mode;
      st_nxt.tablet_seen = 1'b1;
    end
    result.orientation    = st_nxt.display_orient;
    result.rotated        = rot;
    result.auto_mode      = st_nxt.auto_on;
    result.entered_tablet = ent;
    result.left_tablet    = lft;
    result.auto_resumed   = res;
    result.manual_started = man;
    result.step_refused   = refused;
    result.stopped        = st_nxt.halted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.display_orient <= ORIENT_NORMAL;
      st_r.auto_on        <= 1'b1;
      st_r.resume_orient  <= RESUME_NONE;
      st_r.auto_target    <= ORIENT_NORMAL;
      st_r.held_choice    <= ORIENT_NORMAL;
      st_r.tablet_seen    <= 1'b0;
      st_r.tablet_prev    <= 1'b0;
      st_r.halted         <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ rtl/tilt_orientation_controller_top.sv @@
// ----------------------------------------------------------------------------
// tilt_orientation_controller_top
// Tilt-driven screen orientation controller with valid/stall channels.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries the tablet flag, a request code and
// one raw tilt reading; each one produces exactly one result transaction with
// the orientation after that tick and a set of event flags.
// Both channels use valid and stall: a transaction moves on a rising edge
// where valid is high and stall is low. The threshold registers are written
// through cfg_we / cfg_index / cfg_wdata, by the user only while the block is
// idle; the block itself does not enforce this. An accepted transaction sits
// in the input register until the result register is empty or being taken;
// the classify-and-update logic then loads the result register and out_valid
// rises. Throughput is one transaction per cycle while the receiver does not
// stall, set by the single combinational pass between the two registers.
// Reset (synchronous, active low) restores the default thresholds, orientation
// normal, automatic mode on, no resume point, and empties both stages.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more; after that in_stall rises.
// ----------------------------------------------------------------------------
module tilt_orientation_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [tor_pkg::TiltW-1:0]        cfg_wdata,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_tablet_mode,
  input  logic [1:0]                       in_req_type,
  input  logic signed [tor_pkg::TiltW-1:0] in_accel_x,
  input  logic signed [tor_pkg::TiltW-1:0] in_accel_y,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_orientation,
  output logic                             out_rotated,
  output logic                             out_auto_mode,
  output logic                             out_entered_tablet,
  output logic                             out_left_tablet,
  output logic                             out_auto_resumed,
  output logic                             out_manual_started,
  output logic                             out_step_refused,
  output logic                             out_stopped
);
  import tor_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_accept;
  logic    adv;

  // The held item moves into the result register whenever that register is
  // empty or its transaction is being taken in this same cycle.
  assign adv       = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = item_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  // Threshold registers. Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_low   <= TILT_LOW_RST;
      cfg_r.tilt_high  <= TILT_HIGH_RST;
      cfg_r.side_left  <= SIDE_LEFT_RST;
      cfg_r.side_right <= SIDE_RIGHT_RST;
      cfg_r.mid_left   <= MID_LEFT_RST;
      cfg_r.mid_right  <= MID_RIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILT_LOW:   cfg_r.tilt_low   <= cfg_wdata;
        CFG_TILT_HIGH:  cfg_r.tilt_high  <= cfg_wdata;
        CFG_SIDE_LEFT:  cfg_r.side_left  <= cfg_wdata;
        CFG_SIDE_RIGHT: cfg_r.side_right <= cfg_wdata;
        CFG_MID_LEFT:   cfg_r.mid_left   <= cfg_wdata;
        CFG_MID_RIGHT:  cfg_r.mid_right  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_accept) begin
      item_valid_r <= 1'b1;
    end else if (adv) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.tablet_mode <= in_tablet_mode;
      item_r.req_type    <= in_req_type;
      item_r.accel_x     <= in_accel_x;
      item_r.accel_y     <= in_accel_y;
    end
  end

  // Classification and state update; state commits on adv.
  tor_update u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cfg    (cfg_r),
    .item   (item_r),
    .result (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_orientation    = res_r.orientation;
  assign out_rotated        = res_r.rotated;
  assign out_auto_mode      = res_r.auto_mode;
  assign out_entered_tablet = res_r.entered_tablet;
  assign out_left_tablet    = res_r.left_tablet;
  assign out_auto_resumed   = res_r.auto_resumed;
  assign out_manual_started = res_r.manual_started;
  assign out_step_refused   = res_r.step_refused;
  assign out_stopped        = res_r.stopped;

endmodule

@@ rtl/tor_checker.sv @@
// ----------------------------------------------------------------------------
// tor_checker
// Port-level checks for the tilt orientation controller, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tor_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_orientation,
  input logic       out_rotated,
  input logic       out_auto_mode,
  input logic       out_entered_tablet,
  input logic       out_left_tablet,
  input logic       out_auto_resumed,
  input logic       out_manual_started,
  input logic       out_step_refused,
  input logic       out_stopped
);
  import tor_pkg::*;

  // A stalled result stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_orientation) && $stable(out_stopped))

  // A halted block reports no events.
  `ASSERT_SAME(a_stop_quiet, clk, rst_n, out_valid && out_stopped, !out_rotated && !out_entered_tablet && !out_left_tablet && !out_auto_resumed && !out_manual_started && !out_step_refused)

  // Leaving tablet mode forces a rotation to normal.
  `ASSERT_SAME(a_leave_normal, clk, rst_n, out_valid && out_left_tablet, out_rotated && out_orientation == ORIENT_NORMAL && !out_entered_tablet)

  // Resuming automatic mode rotates and turns it on.
  `ASSERT_SAME(a_resume_auto, clk, rst_n, out_valid && out_auto_resumed, out_rotated && out_auto_mode && !out_manual_started)

  // A manual start leaves automatic mode off.
  `ASSERT_SAME(a_manual_off, clk, rst_n, out_valid && out_manual_started, !out_auto_mode && !out_step_refused)

endmodule

bind tilt_orientation_controller_top tor_checker u_tor_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt orientation controller: a tracker class
// mirrors the controller state for every accepted tick and checks each
// result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

class orientation_tracker;

  // Mirrored thresholds and controller state.
  tor_pkg::cfg_t    thr;
  logic [1:0]       orient;
  bit               auto_on;
  logic [2:0]       resume;
  logic [1:0]       target;
  logic [1:0]       held;
  bit               seen;
  bit               prev;
  bit               halted;

  tor_pkg::result_t outcomes_due[$];
  int               errors;
  int               checked;

  function new();
    thr.tilt_low   = tor_pkg::TILT_LOW_RST;
    thr.tilt_high  = tor_pkg::TILT_HIGH_RST;
    thr.side_left  = tor_pkg::SIDE_LEFT_RST;
    thr.side_right = tor_pkg::SIDE_RIGHT_RST;
    thr.mid_left   = tor_pkg::MID_LEFT_RST;
    thr.mid_right  = tor_pkg::MID_RIGHT_RST;
    orient  = tor_pkg::ORIENT_NORMAL;
    auto_on = 1'b1;
    resume  = tor_pkg::RESUME_NONE;
    target  = tor_pkg::ORIENT_NORMAL;
    held    = tor_pkg::ORIENT_NORMAL;
    seen    = 1'b0;
    prev    = 1'b0;
    halted  = 1'b0;
    errors  = 0;
    checked = 0;
  endfunction

  function void set_threshold(logic [2:0] idx, logic [10:0] v);
    case (idx)
      tor_pkg::CFG_TILT_LOW:   thr.tilt_low   = v;
      tor_pkg::CFG_TILT_HIGH:  thr.tilt_high  = v;
      tor_pkg::CFG_SIDE_LEFT:  thr.side_left  = v;
      tor_pkg::CFG_SIDE_RIGHT: thr.side_right = v;
      tor_pkg::CFG_MID_LEFT:   thr.mid_left   = v;
      tor_pkg::CFG_MID_RIGHT:  thr.mid_right  = v;
      default: ;
    endcase
  endfunction

  // Advances the mirrored state by one tick and returns the result it gives.
  function tor_pkg::result_t tick_outcome(tor_pkg::item_t t);
    tor_pkg::result_t o;
    int               x, y, lo, hi, sl, sr, ml, mr;
    logic [1:0]       nxt, c;
    bit               step;
    o    = '0;
    x    = $signed(t.accel_x);
    y    = $signed(t.accel_y);
    y    = -y;
    step = (t.req_type == tor_pkg::REQ_FWD) || (t.req_type == tor_pkg::REQ_BACK);
    if (!halted && t.req_type == tor_pkg::REQ_STOP) begin
      halted = 1'b1;
    end else if (!halted) begin
      if (!seen || prev != t.tablet_mode) begin
        if (t.tablet_mode) begin
          o.entered_tablet = 1'b1;
        end else begin
          o.left_tablet = 1'b1;
          orient        = tor_pkg::ORIENT_NORMAL;
          o.rotated     = 1'b1;
        end
      end
      if (t.tablet_mode) begin
        if (step) begin
          nxt  = (t.req_type == tor_pkg::REQ_FWD) ? orient + 2'd1 : orient - 2'd1;
          held = nxt;
          if ({1'b0, nxt} == resume) begin
            orient         = nxt;
            o.rotated      = 1'b1;
            auto_on        = 1'b1;
            resume         = tor_pkg::RESUME_NONE;
            o.auto_resumed = 1'b1;
          end else if (auto_on && {1'b0, orient} == resume) begin
            auto_on          = 1'b0;
            o.manual_started = 1'b1;
          end else begin
            if (auto_on) begin
              o.manual_started = 1'b1;
              resume           = {1'b0, orient};
            end else begin
              orient    = nxt;
              o.rotated = 1'b1;
            end
            auto_on = 1'b0;
          end
        end
        if (auto_on) begin
          lo = $signed(thr.tilt_low);
          hi = $signed(thr.tilt_high);
          sl = $signed(thr.side_left);
          sr = $signed(thr.side_right);
          ml = $signed(thr.mid_left);
          mr = $signed(thr.mid_right);
          if (y < lo || y > hi) begin
            if (x < sl) c = tor_pkg::ORIENT_LEFT;
            else if (x > sr) c = tor_pkg::ORIENT_RIGHT;
            else c = (y < lo) ? tor_pkg::ORIENT_INVERTED : tor_pkg::ORIENT_NORMAL;
          end else begin
            if (x < ml) c = tor_pkg::ORIENT_LEFT;
            else if (x > mr) c = tor_pkg::ORIENT_RIGHT;
            else c = held;
          end
          held = c;
          if (c != target) begin
            orient    = c;
            o.rotated = 1'b1;
            target    = c;
          end
        end
      end else if (step) begin
        o.step_refused = 1'b1;
      end
      prev = t.tablet_mode;
      seen = 1'b1;
    end
    o.orientation = orient;
    o.auto_mode   = auto_on;
    o.stopped     = halted;
    return o;
  endfunction

  function void note_tick(tor_pkg::item_t t);
    outcomes_due.push_back(tick_outcome(t));
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("tb: result %0d: %s is %0d, predicted %0d", checked, what, got, want);
    errors++;
  endtask

  task cmp(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task check_outcome(tor_pkg::result_t got);
    tor_pkg::result_t want;
    if (outcomes_due.size() == 0) begin
      report_mismatch("unrequested result", 1, 0);
    end else begin
      want = outcomes_due.pop_front();
      cmp("orientation",    got.orientation,    want.orientation);
      cmp("rotated",        got.rotated,        want.rotated);
      cmp("auto_mode",      got.auto_mode,      want.auto_mode);
      cmp("entered_tablet", got.entered_tablet, want.entered_tablet);
      cmp("left_tablet",    got.left_tablet,    want.left_tablet);
      cmp("auto_resumed",   got.auto_resumed,   want.auto_resumed);
      cmp("manual_started", got.manual_started, want.manual_started);
      cmp("step_refused",   got.step_refused,   want.step_refused);
      cmp("stopped",        got.stopped,        want.stopped);
    end
    checked++;
  endtask

endclass

module tb;
  import tor_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [2:0]              cfg_index;
  logic [TiltW-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_tablet_mode;
  logic [1:0]              in_req_type;
  logic signed [TiltW-1:0] in_accel_x;
  logic signed [TiltW-1:0] in_accel_y;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_orientation;
  logic                    out_rotated;
  logic                    out_auto_mode;
  logic                    out_entered_tablet;
  logic                    out_left_tablet;
  logic                    out_auto_resumed;
  logic                    out_manual_started;
  logic                    out_step_refused;
  logic                    out_stopped;

  orientation_tracker book;

  // Idle percentages for the two sides; the stimulus process changes them
  // between phases while both channels are quiet.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // Long receiver hold-off: the stimulus raises hold_go once, and a process
  // of its own counts the stretch out in cycles.
  bit   hold_go = 1'b0;
  logic hold_rx;

  // Current tablet position of the random ticks; it flips now and then.
  bit   tab_now = 1'b1;

  tilt_orientation_controller_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tablet_mode     (in_tablet_mode),
    .in_req_type        (in_req_type),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_orientation    (out_orientation),
    .out_rotated        (out_rotated),
    .out_auto_mode      (out_auto_mode),
    .out_entered_tablet (out_entered_tablet),
    .out_left_tablet    (out_left_tablet),
    .out_auto_resumed   (out_auto_resumed),
    .out_manual_started (out_manual_started),
    .out_step_refused   (out_step_refused),
    .out_stopped        (out_stopped)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Builds one tick from plain integers; the tilt values wrap to 11 bits.
  function automatic item_t make_tick(bit tab, logic [1:0] req, int x, int y);
    item_t t;
    t.tablet_mode = tab;
    t.req_type    = req;
    t.accel_x     = x[10:0];
    t.accel_y     = y[10:0];
    return t;
  endfunction

  function automatic cfg_t thresholds(int lo, int hi, int sl, int sr, int ml, int mr);
    cfg_t c;
    c.tilt_low   = lo[10:0];
    c.tilt_high  = hi[10:0];
    c.side_left  = sl[10:0];
    c.side_right = sr[10:0];
    c.mid_left   = ml[10:0];
    c.mid_right  = mr[10:0];
    return c;
  endfunction

  // Random thresholds over the whole range. When ordered is set, each pair
  // is put low-then-high so that all four bands actually exist.
  function automatic cfg_t random_thresholds(bit ordered);
    int v[6];
    int s;
    foreach (v[i]) v[i] = int'($urandom_range(2047)) - 1024;
    if (ordered) begin
      for (int p = 0; p < 6; p += 2) begin
        if (v[p] > v[p+1]) begin
          s      = v[p];
          v[p]   = v[p+1];
          v[p+1] = s;
        end
      end
    end
    return thresholds(v[0], v[1], v[2], v[3], v[4], v[5]);
  endfunction

  // Mostly a value a few counts either side of a threshold, where the
  // classification changes; now and then anything at all.
  function automatic int near_value(int mark);
    if ($urandom_range(99) < 25) return int'($urandom_range(2047)) - 1024;
    return mark + int'($urandom_range(6)) - 3;
  endfunction

  // A random tick that keeps the controller busy: occasional lid changes, a
  // fair share of manual steps, and tilt readings clustered on the current
  // thresholds. Stop is left out on purpose, since it halts the block until
  // reset.
  function automatic item_t next_tick();
    int         pick, x, y;
    logic [1:0] req;
    if ($urandom_range(99) < 4) tab_now = !tab_now;
    pick = $urandom_range(99);
    if (pick < 62) req = REQ_NONE;
    else if (pick < 81) req = REQ_FWD;
    else req = REQ_BACK;
    case ($urandom_range(3))
      0:       x = near_value($signed(book.thr.side_left));
      1:       x = near_value($signed(book.thr.side_right));
      2:       x = near_value($signed(book.thr.mid_left));
      default: x = near_value($signed(book.thr.mid_right));
    endcase
    // The controller negates Y, so aim the raw reading at minus a limit.
    if ($urandom_range(1)) y = -near_value($signed(book.thr.tilt_low));
    else y = -near_value($signed(book.thr.tilt_high));
    return make_tick(tab_now, req, x, y);
  endfunction

  // Offers one transaction, idling first at the current rate, and returns at
  // the edge where it is taken. in_valid is left high so that back-to-back
  // transactions never lower and raise it within one time step.
  task automatic send_tick(input item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_tablet_mode <= t.tablet_mode;
    in_req_type    <= t.req_type;
    in_accel_x     <= t.accel_x;
    in_accel_y     <= t.accel_y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_tick(t);
  endtask

  // Closes a burst and waits until every predicted result has been checked.
  // Each tick gives exactly one result, so nothing is left in flight then;
  // the short pause covers the two-stage pipeline anyway.
  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (book.outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_threshold(input logic [2:0] idx, input logic [TiltW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    book.set_threshold(idx, v);
  endtask

  // Writes all six thresholds on consecutive edges; only called while idle.
  task automatic load_thresholds(input cfg_t c);
    put_threshold(CFG_TILT_LOW,   c.tilt_low);
    put_threshold(CFG_TILT_HIGH,  c.tilt_high);
    put_threshold(CFG_SIDE_LEFT,  c.side_left);
    put_threshold(CFG_SIDE_RIGHT, c.side_right);
    put_threshold(CFG_MID_LEFT,   c.mid_left);
    put_threshold(CFG_MID_RIGHT,  c.mid_right);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_burst(input int n);
    repeat (n) send_tick(next_tick());
    drain_ticks();
  endtask

  // Result side: check every transaction taken, then pick the stall for the
  // next edge. Everything is sampled right at the edge, before any of this
  // step's nonblocking updates land.
  initial begin : result_sink
    result_t got;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.orientation    = out_orientation;
        got.rotated        = out_rotated;
        got.auto_mode      = out_auto_mode;
        got.entered_tablet = out_entered_tablet;
        got.left_tablet    = out_left_tablet;
        got.auto_resumed   = out_auto_resumed;
        got.manual_started = out_manual_started;
        got.step_refused   = out_step_refused;
        got.stopped        = out_stopped;
        book.check_outcome(got);
      end
      out_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // One long receiver hold-off. The sender keeps offering transactions, so
  // both pipeline stages fill and in_stall has to rise.
  initial begin : receiver_hold
    hold_rx <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (48) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    book           = new();
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_TILT_LOW;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_tablet_mode <= 1'b0;
    in_req_type    <= REQ_NONE;
    in_accel_x     <= '0;
    in_accel_y     <= '0;
    send_idle_pct  = 36;
    recv_idle_pct  = 85;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks with the reset thresholds (465/525, 210/425, 305/345).
    // The first tick is outside tablet mode, then steps are refused there.
    send_tick(make_tick(1'b0, REQ_NONE, 0, 0));
    send_tick(make_tick(1'b0, REQ_FWD, 5, 5));
    send_tick(make_tick(1'b0, REQ_BACK, -5, -5));
    // Entering tablet mode, then each band of the classifier.
    send_tick(make_tick(1'b1, REQ_NONE, 0, 0));
    send_tick(make_tick(1'b1, REQ_NONE, 1023, -1024));
    send_tick(make_tick(1'b1, REQ_NONE, 300, -600));
    send_tick(make_tick(1'b1, REQ_NONE, 300, -100));
    // Middle band with X between the middle limits keeps the held choice.
    send_tick(make_tick(1'b1, REQ_NONE, 320, -500));
    send_tick(make_tick(1'b1, REQ_NONE, 200, -500));
    send_tick(make_tick(1'b1, REQ_NONE, 400, -500));
    send_tick(make_tick(1'b1, REQ_NONE, -1024, 1023));
    // Exact threshold values sit inside the bands they bound.
    send_tick(make_tick(1'b1, REQ_NONE, 305, -465));
    send_tick(make_tick(1'b1, REQ_NONE, 345, -525));
    send_tick(make_tick(1'b1, REQ_NONE, 210, -600));
    send_tick(make_tick(1'b1, REQ_NONE, 425, -100));
    // The first step turns automatic mode off, further steps rotate, and
    // stepping back onto the recorded orientation resumes automatic mode;
    // the fifth one resumes and then rotates again in the same tick.
    send_tick(make_tick(1'b1, REQ_FWD, 320, -495));
    send_tick(make_tick(1'b1, REQ_FWD, 320, -495));
    send_tick(make_tick(1'b1, REQ_FWD, 0, 0));
    send_tick(make_tick(1'b1, REQ_BACK, 0, 0));
    send_tick(make_tick(1'b1, REQ_BACK, 1023, -1024));
    send_tick(make_tick(1'b1, REQ_BACK, 0, 0));
    // Leaving tablet mode forces normal orientation, even when repeated.
    send_tick(make_tick(1'b0, REQ_NONE, 1023, 1023));
    send_tick(make_tick(1'b0, REQ_NONE, -1, -1));
    send_tick(make_tick(1'b1, REQ_FWD, -1024, -1024));
    send_tick(make_tick(1'b0, REQ_BACK, -1, 1023));
    drain_ticks();

    // Sender idles often, receiver stalls most of the time.
    load_thresholds(thresholds(-1024, -1024, -1024, -1024, -1024, -1024));
    random_burst(60);
    load_thresholds(thresholds(1023, 1023, 1023, 1023, 1023, 1023));
    random_burst(60);
    load_thresholds(random_thresholds(1'b1));
    random_burst(170);

    // The other way round.
    send_idle_pct = 85;
    recv_idle_pct = 36;
    load_thresholds(random_thresholds(1'b0));
    random_burst(170);
    load_thresholds(random_thresholds(1'b1));
    random_burst(170);

    // Full rate on both sides, with the long hold-off at the start.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_thresholds(thresholds(465, 525, 210, 425, 305, 345));
    hold_go = 1'b1;
    random_burst(170);

    // Stop halts the controller for good, so it comes last; the ticks after
    // it, stops and steps among them, must change nothing.
    repeat (6) send_tick(next_tick());
    send_tick(make_tick(1'b1, REQ_STOP, 0, 0));
    repeat (10)
      send_tick(make_tick(1'($urandom_range(1)), 2'($urandom_range(3)),
                          int'($urandom_range(2047)) - 1024,
                          int'($urandom_range(2047)) - 1024));
    drain_ticks();

    // Any result showing up now has no prediction and is flagged.
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
